// File: rtl/u8f_pkg.sv
// ----------------------------------------------------------------------------
// u8f_pkg: shared types and tables for the UTF-8 to ASCII text folder
// Request and response payloads, the decoded burst passed from the decoder
// to the serializer, break pairing codes and the substitution table.
// ----------------------------------------------------------------------------
package u8f_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [1:0] PAIR_NONE = 2'd0;
   localparam logic [1:0] PAIR_CR   = 2'd1;
   localparam logic [1:0] PAIR_LF   = 2'd2;

   localparam logic [7:0]  CHAR_CR    = 8'h0D;
   localparam logic [20:0] CP_CR      = 21'h00000D;
   localparam logic [20:0] CP_LF      = 21'h00000A;
   localparam logic [20:0] CP_NEL     = 21'h000085;
   localparam logic [20:0] CP_LINE_SEP = 21'h002028;
   localparam logic [20:0] CP_PARA_SEP = 21'h002029;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
   } rsp_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;
   } burst_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [1:0]      len;
      logic [2:0][7:0] text;
   } sub_type;

   function automatic sub_type sub_lookup(input logic [20:0] cp);
      sub_type res;
      res.len  = 2'd1;
      res.text = '0;
      unique case (cp)
         21'h002018, 21'h002019, 21'h00201A: res.text[0] = 8'h27;
         21'h00201C, 21'h00201D, 21'h00201E: res.text[0] = 8'h22;
         21'h002013, 21'h002014, 21'h002015, 21'h002212: res.text[0] = 8'h2D;
         21'h002026: begin
            res.len  = 2'd3;
            res.text = {8'h2E, 8'h2E, 8'h2E};
         end
         21'h0000A0: res.text[0] = 8'h20;
         21'h002022, 21'h0000D7: res.text[0] = 8'h2A;
         21'h002190: res.text[0] = 8'h5B;
         21'h0000BD: res.text[0] = 8'h5C;
         21'h002192: res.text[0] = 8'h5D;
         21'h002191: res.text[0] = 8'h5E;
         21'h0000BC: res.text[0] = 8'h7B;
         21'h002016: res.text[0] = 8'h7C;
         21'h0000BE: res.text[0] = 8'h7D;
         21'h0000F7: res.text[0] = 8'h7E;
         default: res.len = 2'd0;
      endcase
      return res;
   endfunction

endpackage

// File: rtl/utf8_to_ascii_text_folder_core.sv
// ----------------------------------------------------------------------------
// utf8_to_ascii_text_folder_core: UTF-8 to ASCII text folder
// Path: when the serializer is idle, the first response byte of a request is
// written to the burst queue and then loaded into the serializer's output register.
// Throughput: one request per cycle while the burst queue has room; responses
// leave at one byte per cycle while the consumer pops and bursts are queued.
// Reset clears the decode state, the pending break and the queue.
// ----------------------------------------------------------------------------
module utf8_to_ascii_text_folder_core
   import u8f_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   queue_status_type status;
   burst_type        wr_burst, rd_burst;
   logic             accept, push, pop;

   assign req_full = status.full;
   assign accept   = req_push && !status.full;

   u8f_front front (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .accept   (accept),
      .burst    (wr_burst),
      .push     (push)
   );

   u8f_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (wr_burst),
      .pop     (pop),
      .rd_data (rd_burst),
      .status  (status)
   );

   u8f_back back (
      .clock     (clock),
      .reset     (reset),
      .rd_data   (rd_burst),
      .status    (status),
      .pop       (pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/u8f_front.sv
// ----------------------------------------------------------------------------
// u8f_front: UTF-8 decoder front end
// Decodes one accepted request byte per cycle, tracks the partial sequence
// and the pending line break, and forms the burst of up to four output bytes.
// ----------------------------------------------------------------------------
module u8f_front
   import u8f_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  req_type   req_data,
   input  logic      accept,
   output burst_type burst,
   output logic      push
);

   logic [7:0]  held_ff [3];
   logic [1:0]  hcnt_ff, hcnt_in;
   logic [2:0]  slen_ff, slen_in;
   logic [20:0] cp_ff, cp_in;
   logic [1:0]  pair_ff, pair_in;

   logic [7:0]  b;
   logic        last;
   logic        cont, flush, done, hold, fresh;
   logic        is_ascii, lead2, lead3, lead4;
   logic        fresh_ascii, fresh_lead, fresh_bad;
   logic        fin, swallow, brk, is_sub, raw;
   logic [20:0] ncp, fin_cp, lead_cp;
   logic [2:0]  lead_len;
   logic [1:0]  pend, h, f;
   logic        bb;
   logic [2:0][7:0] ftext;
   sub_type     sub;

   always_comb begin
      b     = req_data.in_byte;
      last  = req_data.in_last;
      cont  = (slen_ff != 3'd0) && (b[7:6] == 2'b10);
      flush = (slen_ff != 3'd0) && (b[7:6] != 2'b10);
      ncp   = {cp_ff[14:0], b[5:0]};
      done  = cont && (({1'b0, hcnt_ff} + 3'd1) >= slen_ff);
      hold  = cont && !done;
      fresh = !cont;

      is_ascii = !b[7];
      lead2    = b[7:5] == 3'b110;
      lead3    = b[7:4] == 4'b1110;
      lead4    = b[7:3] == 5'b11110;
      fresh_ascii = fresh && is_ascii;
      fresh_lead  = fresh && (lead2 || lead3 || lead4);
      fresh_bad   = fresh && !is_ascii && !lead2 && !lead3 && !lead4;

      lead_len = lead2 ? 3'd2 : lead3 ? 3'd3 : 3'd4;
      lead_cp  = lead2 ? {16'd0, b[4:0]} : lead3 ? {17'd0, b[3:0]} : {18'd0, b[2:0]};

      fin    = done || fresh_ascii;
      fin_cp = done ? ncp : {13'd0, b};
      pend   = flush ? PAIR_NONE : pair_ff;

      swallow = fin && (((pend == PAIR_CR) && (fin_cp == CP_LF)) ||
                        ((pend == PAIR_LF) && (fin_cp == CP_CR)));
      brk = fin && !swallow && ((fin_cp == CP_CR) || (fin_cp == CP_LF) ||
                                (fin_cp == CP_NEL) || (fin_cp == CP_LINE_SEP) ||
                                (fin_cp == CP_PARA_SEP));
      sub    = sub_lookup(fin_cp);
      is_sub = fin && !swallow && !brk && (sub.len != 2'd0);
      raw    = fin && !swallow && !brk && !is_sub;

      h     = (flush || (done && raw) || (hold && last)) ? hcnt_ff : 2'd0;
      f     = brk ? 2'd1 : (is_sub ? sub.len : 2'd0);
      ftext = brk ? {8'h00, 8'h00, CHAR_CR} : sub.text;
      bb    = raw || fresh_bad || (last && (hold || fresh_lead));
   end

   always_comb begin
      logic [2:0] rel;
      rel = '0;
      for (int k = 0; k < 4; k++) begin
         rel = 3'(k) - {1'b0, h};
         if ((k < 3) && (3'(k) < {1'b0, h})) begin
            burst.bytes[k] = held_ff[2'(k)];
         end else if (rel < {1'b0, f}) begin
            burst.bytes[k] = ftext[rel[1:0]];
         end else begin
            burst.bytes[k] = b;
         end
      end
      burst.count = {1'b0, h} + {1'b0, f} + {2'b0, bb};
      push        = accept && (burst.count != 3'd0);
   end

   always_comb begin
      hcnt_in = hcnt_ff;
      slen_in = slen_ff;
      cp_in   = cp_ff;
      pair_in = pair_ff;
      if (accept) begin
         if (last) begin
            pair_in = PAIR_NONE;
         end else if (fin) begin
            pair_in = !brk ? PAIR_NONE :
                      (fin_cp == CP_CR) ? PAIR_CR :
                      (fin_cp == CP_LF) ? PAIR_LF : PAIR_NONE;
         end else if (flush || fresh_bad) begin
            pair_in = PAIR_NONE;
         end

         if (last) begin
            hcnt_in = '0;
            slen_in = '0;
            cp_in   = '0;
         end else if (hold) begin
            hcnt_in = hcnt_ff + 2'd1;
            cp_in   = ncp;
         end else if (fresh_lead) begin
            hcnt_in = 2'd1;
            slen_in = lead_len;
            cp_in   = lead_cp;
         end else begin
            hcnt_in = '0;
            slen_in = '0;
            cp_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hcnt_ff <= '0;
         slen_ff <= '0;
         cp_ff   <= '0;
         pair_ff <= PAIR_NONE;
      end else begin
         hcnt_ff <= hcnt_in;
         slen_ff <= slen_in;
         cp_ff   <= cp_in;
         pair_ff <= pair_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && hold) begin
         held_ff[hcnt_ff] <= b;
      end else if (accept && fresh_lead) begin
         held_ff[0] <= b;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      push |-> (burst.count <= 3'd4))
      else $error("Burst holds more than four bytes.");

   assert property (@(posedge clock) disable iff (reset)
      (slen_ff == 3'd0) |-> ((hcnt_ff == 2'd0) && (cp_ff == 21'd0)))
      else $error("Decode state left behind while idle.");

endmodule

// File: rtl/u8f_queue.sv
// ----------------------------------------------------------------------------
// u8f_queue: burst queue between decoder and serializer
// A small circular buffer of decoded bursts with full and empty status.
// ----------------------------------------------------------------------------
module u8f_queue
   import u8f_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  burst_type        wr_data,
   input  logic             pop,
   output burst_type        rd_data,
   output queue_status_type status
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   burst_type      mem [DEPTH];
   logic [AW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]  cnt_ff, cnt_in;

   always_comb begin
      status.full  = cnt_ff == CW'(DEPTH);
      status.empty = cnt_ff == '0;
      rd_data      = mem[rd_ff];
      wr_in  = push ? ((wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = pop ? ((rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= wr_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      !(push && status.full))
      else $error("Burst written into a full queue.");

   assert property (@(posedge clock) disable iff (reset)
      !(pop && status.empty))
      else $error("Burst read from an empty queue.");

endmodule

// File: rtl/u8f_back.sv
// ----------------------------------------------------------------------------
// u8f_back: burst serializer
// Holds the current burst in an output register and hands out its bytes one
// per response, marking the last byte of each burst.
// ----------------------------------------------------------------------------
module u8f_back
   import u8f_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  burst_type        rd_data,
   input  queue_status_type status,
   output logic             pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output rsp_type          rsp_data
);

   burst_type  cur_ff, cur_in;
   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic       last_byte, take, load;

   always_comb begin
      last_byte = {1'b0, idx_ff} == (cur_ff.count - 3'd1);
      take      = valid_ff && rsp_pop;
      load      = !valid_ff || (take && last_byte);
      pop       = load && !status.empty;
      valid_in  = load ? !status.empty : valid_ff;
      cur_in    = pop ? rd_data : cur_ff;
      idx_in    = load ? 2'd0 : (take ? idx_ff + 2'd1 : idx_ff);

      rsp_empty         = !valid_ff;
      rsp_data.out_byte = cur_ff.bytes[idx_ff];
      rsp_data.run_last = last_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (({1'b0, idx_ff} < cur_ff.count) && (cur_ff.count != 3'd0)))
      else $error("Response index runs past the current burst.");

endmodule
